// ===== src/smx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_pkg
// Shared types and constants of the softmax core.
// ----------------------------------------------------------------------------
package smx_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned ProbW   = 16;
  localparam int unsigned SumW    = 23;

  // exp(-1/256) in Q0.32
  localparam logic [32:0] ExpBaseQ32 = 33'd4278222805;
  localparam logic [32:0] OneQ32     = 33'h1_0000_0000;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      last_in;
  } smx_in_t;

  typedef struct packed {
    logic [ProbW-1:0] probability;
    logic             last_out;
    logic             overflow;
  } smx_out_t;

endpackage

// ===== src/smx_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_stream_if
// Valid/ready channel carrying one payload word per transaction.
// ----------------------------------------------------------------------------
interface smx_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/smx_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_mul
// Shared registered 33x33 multiplier, built from four 17x17 partial
// products accumulated in turn; result = (a * b + 2^31) >> 32 (33 bits).
// ----------------------------------------------------------------------------
module smx_mul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [32:0] a_i,
  input  logic [32:0] b_i,
  output logic        done_o,
  output logic [32:0] res_o
);
  logic [32:0] a_q, b_q;
  logic [67:0] acc_q;
  logic [2:0]  step_q;
  logic        busy_q;
  logic [16:0] pa, pb;
  logic [33:0] prod;
  logic [67:0] acc_sum;

  // select one partial product a half times b half
  always_comb begin
    pa = step_q[1] ? {1'b0, a_q[32:17]} : a_q[16:0];
    pb = step_q[0] ? {1'b0, b_q[32:17]} : b_q[16:0];
    prod = {17'd0, pa} * {17'd0, pb};
    acc_sum = acc_q + ({34'd0, prod} << (7'd17 * {5'd0, step_q[1]}
                                         + 7'd17 * {5'd0, step_q[0]}));
  end

  assign res_o = acc_q[64:32];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 3'd1;
        if (step_q == 3'd3) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= 68'h8000_0000;
    end else if (busy_q) begin
      acc_q <= acc_sum;
    end
  end
endmodule

// ===== src/softmax_forward_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// softmax_forward_core
// Max-subtracted softmax over a vector of signed Q8.8 samples.
// ----------------------------------------------------------------------------
// Elements load at one per cycle into a store of MAX_LEN entries while the
// maximum is tracked. The marked last element starts two passes over the
// store: a sum pass and an output pass. Each pass computes exp(x - max) by
// binary exponentiation on one shared multiplier, using 12 to 24 products,
// and skips the multiplier when x is 16 or more below the max. The output
// pass then runs a 17-step restoring division by the sum and an emit state.
// The input is not ready until the final result is emitted.
// ----------------------------------------------------------------------------
module softmax_forward_core #(
  parameter int unsigned MAX_LEN = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  smx_stream_if.sink   in_i,
  smx_stream_if.source out_o
);
  import smx_pkg::*;

  localparam int unsigned IdxW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned CntW = $clog2(MAX_LEN + 1);

  localparam logic [3:0] StLoad   = 4'd0;
  localparam logic [3:0] StRead   = 4'd1;
  localparam logic [3:0] StExpBeg = 4'd2;
  localparam logic [3:0] StRMul   = 4'd3;
  localparam logic [3:0] StRWait  = 4'd4;
  localparam logic [3:0] StBMul   = 4'd5;
  localparam logic [3:0] StBWait  = 4'd6;
  localparam logic [3:0] StExpEnd = 4'd7;
  localparam logic [3:0] StDiv    = 4'd8;
  localparam logic [3:0] StEmit   = 4'd9;

  logic [SampleW-1:0] store_mem [MAX_LEN];
  logic [SampleW-1:0] rd_q;
  logic [3:0]         state_q;
  logic signed [SampleW-1:0] max_q;
  logic [CntW-1:0]    count_q;
  logic [IdxW-1:0]    idx_q;
  logic               pass_q;     // 0 sum pass, 1 output pass
  logic               ovf_q;
  logic [SumW-1:0]    sum_q;
  logic [15:0]        n_q;
  logic [3:0]         bit_q;
  logic [32:0]        r_q, base_q;
  logic [40:0]        rem_q;      // remainder over pending dividend bits
  logic [16:0]        quo_q;
  logic [4:0]         dstep_q;
  logic               mul_start;
  logic [32:0]        mul_a, mul_b, mul_res;
  logic               mul_done;
  logic               out_valid_q;
  smx_out_t           out_q;
  logic               accept;
  logic               emit;
  logic [16:0]        diff;
  logic [33:0]        e_round;
  logic [24:0]        trial;

  assign accept      = in_i.valid && in_i.ready;
  assign in_i.ready  = (state_q == StLoad);
  assign out_o.valid = out_valid_q;
  assign out_o.payload = out_q;
  assign emit        = (state_q == StEmit) && (!out_valid_q || out_o.ready);

  assign diff    = {max_q[15], max_q} - {rd_q[15], rd_q};
  assign e_round = {1'b0, r_q} + 34'd32768;
  assign trial   = {1'b0, rem_q[39:16]} - {2'b00, sum_q};

  assign mul_start = (state_q == StRMul) || (state_q == StBMul);
  assign mul_a     = (state_q == StRMul) ? r_q : base_q;
  assign mul_b     = base_q;

  smx_mul u_mul (
    .clk_i, .rst_ni,
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  // store write and registered read
  always_ff @(posedge clk_i) begin
    if (accept && count_q < CntW'(MAX_LEN)) begin
      store_mem[count_q[IdxW-1:0]] <= in_i.payload.sample;
    end
    rd_q <= store_mem[idx_q];
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      max_q       <= 16'sh8000;
      count_q     <= '0;
      idx_q       <= '0;
      pass_q      <= 1'b0;
      ovf_q       <= 1'b0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) out_valid_q <= 1'b1;
      else if (out_o.valid && out_o.ready) out_valid_q <= 1'b0;
      unique case (state_q)
        StLoad: begin
          if (accept) begin
            if (count_q < CntW'(MAX_LEN)) begin
              count_q <= count_q + CntW'(1);
              if (in_i.payload.sample > max_q) max_q <= in_i.payload.sample;
            end else begin
              ovf_q <= 1'b1;
            end
            if (in_i.payload.last_in) begin
              idx_q   <= '0;
              pass_q  <= 1'b0;
              sum_q   <= '0;
              state_q <= StRead;
            end
          end
        end
        StRead: state_q <= StExpBeg;   // read data lands in rd_q
        StExpBeg: begin
          n_q    <= diff[15:0];
          base_q <= ExpBaseQ32;
          bit_q  <= '0;
          if (diff[15:12] != 4'd0) begin
            r_q     <= '0;
            state_q <= StExpEnd;
          end else begin
            r_q     <= OneQ32;
            state_q <= StRMul;
          end
        end
        StRMul: begin
          if (n_q[bit_q]) state_q <= StRWait;
          else            state_q <= StBMul;
        end
        StRWait: if (mul_done) begin r_q <= mul_res; state_q <= StBMul; end
        StBMul: state_q <= StBWait;
        StBWait: begin
          if (mul_done) begin
            base_q <= mul_res;
            bit_q  <= bit_q + 4'd1;
            state_q <= (bit_q == 4'd11) ? StExpEnd : StRMul;
          end
        end
        StExpEnd: begin
          logic [15:0] e;
          e = (e_round[33:16] > 18'd65535) ? 16'hFFFF : e_round[31:16];
          if (!pass_q) begin
            sum_q <= sum_q + {7'd0, e};
            if (idx_q == IdxW'(count_q - CntW'(1))) begin
              idx_q  <= '0;
              pass_q <= 1'b1;
            end else begin
              idx_q <= idx_q + IdxW'(1);
            end
            state_q <= StRead;
          end else begin
            rem_q   <= {9'd0, e, 16'd0} + 41'(sum_q >> 1);
            quo_q   <= '0;
            dstep_q <= '0;
            state_q <= StDiv;
          end
        end
        StDiv: begin
          // dividend e*65536 + sum/2, one bit per step, 17 quotient bits
          if (!trial[24]) begin
            rem_q <= {trial[23:0], rem_q[15:0], 1'b0};
            quo_q <= {quo_q[15:0], 1'b1};
          end else begin
            rem_q <= {rem_q[39:0], 1'b0};
            quo_q <= {quo_q[15:0], 1'b0};
          end
          dstep_q <= dstep_q + 5'd1;
          if (dstep_q == 5'd16) state_q <= StEmit;
        end
        StEmit: begin
          if (emit) begin
            out_q.probability <= quo_q[16] ? 16'hFFFF : quo_q[15:0];
            out_q.overflow    <= ovf_q;
            if (idx_q == IdxW'(count_q - CntW'(1))) begin
              out_q.last_out <= 1'b1;
              max_q   <= 16'sh8000;
              count_q <= '0;
              ovf_q   <= 1'b0;
              sum_q   <= '0;
              state_q <= StLoad;
            end else begin
              out_q.last_out <= 1'b0;
              idx_q   <= idx_q + IdxW'(1);
              state_q <= StRead;
            end
          end
        end
        default: state_q <= StLoad;
      endcase
    end
  end

  // output must not change while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.payload))
    else $error("output transaction changed while stalled");
  // no input transaction while results are being computed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StLoad |-> !in_i.ready)
    else $error("input ready outside load phase");
  // element count never exceeds the store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_LEN))
    else $error("element count beyond store size");
endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the max-subtracted softmax core.
// ----------------------------------------------------------------------------
// Vectors of Q8.8 samples are streamed in under random source gaps while the
// result channel stalls at random. A scoreboard predicts every probability,
// last marker and overflow flag, and compares each result transaction with
// the oldest expected one. Directed vectors cover field extremes, a single
// element, a full store, overflow and a dropped final element.
// ----------------------------------------------------------------------------
module tb_top;
  import smx_pkg::*;

  localparam int unsigned StoreLen = 32;
  localparam longint unsigned CycleLimit = 4_000_000;

  // Softmax predictor and queue of expected results
  class softmax_scoreboard;
    logic [15:0]  stored_samples[StoreLen];
    int           stored_count;
    int           vec_max;
    bit           dropped;
    smx_out_t     expected_results[$];
    int           mismatches;

    function new();
      mismatches = 0;
      clear();
    endfunction

    function void clear();
      stored_count = 0;
      vec_max = -32768;
      dropped = 0;
    endfunction

    // exp(-n/256) in Q0.16 by binary exponentiation in Q0.32
    function automatic logic [15:0] exp_q16(int unsigned n);
      logic [63:0] r;
      logic [63:0] base;
      logic [63:0] e;
      r = 64'h1_0000_0000;
      base = 64'd4278222805;
      if (n >= 4096) return 16'd0;
      for (int b = 0; b < 12; b++) begin
        if (n[b]) r = (r * base + 64'h8000_0000) >> 32;
        base = (base * base + 64'h8000_0000) >> 32;
      end
      e = (r + 64'd32768) >> 16;
      if (e > 64'd65535) e = 64'd65535;
      return e[15:0];
    endfunction

    function void note_input(smx_in_t item);
      logic [22:0] sum;
      logic [63:0] p;
      logic [15:0] e;
      smx_out_t res;
      int x;
      if (stored_count < StoreLen) begin
        stored_samples[stored_count] = item.sample;
        stored_count++;
        x = int'(item.sample);
        if (x > vec_max) vec_max = x;
      end else begin
        dropped = 1;
      end
      if (!item.last_in) return;
      sum = '0;
      for (int i = 0; i < stored_count; i++)
        sum += exp_q16(vec_max - int'($signed(stored_samples[i])));
      for (int i = 0; i < stored_count; i++) begin
        e = exp_q16(vec_max - int'($signed(stored_samples[i])));
        p = (64'(e) * 64'd65536 + 64'(sum >> 1)) / 64'(sum);
        if (p > 64'd65535) p = 64'd65535;
        res.probability = p[15:0];
        res.last_out = (i + 1 == stored_count);
        res.overflow = dropped;
        expected_results = {expected_results, res};
      end
      clear();
    endfunction

    task check_result(smx_out_t got);
      smx_out_t exp_res;
      if (expected_results.size() == 0) begin
        report("unexpected result transaction");
        return;
      end
      exp_res = expected_results.pop_front();
      if (got.probability !== exp_res.probability)
        report($sformatf("probability got %0d want %0d", got.probability,
                         exp_res.probability));
      if (got.last_out !== exp_res.last_out)
        report($sformatf("last_out got %0b want %0b", got.last_out, exp_res.last_out));
      if (got.overflow !== exp_res.overflow)
        report($sformatf("overflow got %0b want %0b", got.overflow, exp_res.overflow));
    endtask

    task report(string msg);
      mismatches++;
      $display("MISMATCH %0t: %s", $time, msg);
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  longint unsigned cycle_count = 0;
  bit stim_done = 0;

  smx_stream_if #(.payload_t(smx_in_t))  in_if ();
  smx_stream_if #(.payload_t(smx_out_t)) out_if ();

  softmax_forward_core #(.MAX_LEN(StoreLen)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  softmax_scoreboard sb = new();

  always #5 clk_i = ~clk_i;

  initial begin
    in_if.valid = 1'b0;
    in_if.payload = '0;
    out_if.ready = 1'b0;
  end

  // Timeout guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Result sink with random stalls
  initial begin : result_sink
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_if.valid) @(posedge clk_i);
      sb.check_result(out_if.payload);
    end
  end

  // Drive one element, waiting for acceptance
  task automatic send_sample(logic [15:0] s, logic last, bit no_gap = 0);
    smx_in_t item;
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item.sample = s;
    item.last_in = last;
    in_if.payload <= item;
    in_if.valid <= 1'b1;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_input(item);
  endtask

  task automatic send_vector(int len, int mode, bit no_gap = 0);
    logic [15:0] s;
    int centre;
    centre = $urandom_range(0, 65535);
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: s = $urandom_range(0, 65535);
        1: s = 16'(centre + $urandom_range(0, 2048) - 1024);
        default: s = 16'(centre + $urandom_range(0, 8192) - 4096);
      endcase
      send_sample(s, i == len - 1, no_gap);
    end
  endtask

  initial begin : stimulus
    int len;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: single element, extremes, equal values, far apart
    send_sample(16'h7fff, 1'b1);
    send_sample(16'h8000, 1'b1);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7fff, 1'b1);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'hffff, 1'b1);
    send_sample(16'h0100, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'hf001, 1'b0);
    send_sample(16'hf000, 1'b1);
    // Store exactly full, then overflow, then final element dropped
    send_vector(StoreLen, 1, 1);
    send_vector(StoreLen + 3, 2);
    send_vector(StoreLen + 1, 1);

    // Random vectors, mostly short
    for (int n = 0; n < 290; n += len) begin
      case ($urandom_range(0, 9))
        0: len = $urandom_range(StoreLen - 1, StoreLen + 4);
        default: len = $urandom_range(1, 8);
      endcase
      send_vector(len, $urandom_range(0, 2), $urandom_range(0, 4) == 0);
    end
    in_if.valid <= 1'b0;

    while (sb.expected_results.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
